// ===== rtl/lbre_pkg.sv =====
// Shared types and constants of the LED bank ripple envelope.
`timescale 1ns / 1ps
package lbre_pkg;

  localparam int BANK_COUNT = 9;
  localparam int BANK_W = 4;
  localparam logic [BANK_W-1:0] LAST_BANK = BANK_W'(BANK_COUNT - 1);
  localparam logic [7:0] BLOW_PEAK = 8'd100;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_ORIGIN = 3'd1,
    REG_STEP   = 3'd2,
    REG_PEAK   = 3'd3,
    REG_PASSES = 3'd4,
    REG_ANCHOR = 3'd5
  } reg_idx_t;

  // Ripple modes
  localparam logic MODE_OUTWARD = 1'b0;
  localparam logic MODE_BLOW = 1'b1;

  // Configuration as seen by the back end (origin already clamped)
  typedef struct packed {
    logic        mode;
    logic [3:0]  origin;
    logic [15:0] step;
    logic [7:0]  peak;
    logic [3:0]  anchor;
    logic [19:0] cycle;
  } cfg_t;

  // One queued item: time and its finished classification
  typedef struct packed {
    logic [31:0] t;
    logic        fin;
  } item_t;

  // Serial divider request and response
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [19:0] divisor;
    logic [5:0]  nsteps;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [19:0] rem;
  } div_rsp_t;

endpackage

// ===== rtl/lbre_front.sv =====
// Front end: takes time items and classifies them as finished or active.
`timescale 1ns / 1ps
module lbre_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        elapsed_ms,
  input  logic [27:0]        total,
  output logic               push_valid,
  input  logic               push_ready,
  output lbre_pkg::item_t    push_item
);

  logic        va;
  logic [31:0] ta;
  logic        vb;
  logic [31:0] tb;
  logic        rdy_a;
  logic        rdy_b;

  assign rdy_b = !vb || push_ready;
  assign rdy_a = !va || rdy_b;
  assign in_ready = rdy_a;

  // Two capture stages; the second compares against the derived total
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (rdy_a) begin
        va <= in_valid;
      end
      if (rdy_b) begin
        vb <= va;
      end
    end
    if (rdy_a && in_valid) begin
      ta <= elapsed_ms;
    end
    if (rdy_b && va) begin
      tb <= ta;
    end
  end

  assign push_valid = vb;
  assign push_item.t = tb;
  assign push_item.fin = (tb >= 32'(total));

endmodule

// ===== rtl/lbre_fifo.sv =====
// Short queue of classified items between front and back.
`timescale 1ns / 1ps
module lbre_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  lbre_pkg::item_t  wr_item,
  output logic             rd_valid,
  input  logic             rd_ready,
  output lbre_pkg::item_t  rd_item
);

  lbre_pkg::item_t mem [lbre_pkg::FIFO_DEPTH];
  logic [lbre_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [lbre_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [lbre_pkg::FIFO_CNT_W-1:0] count;
  logic do_wr;
  logic do_rd;

  assign wr_ready = (count != lbre_pkg::FIFO_CNT_W'(lbre_pkg::FIFO_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item = mem[rd_ptr];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_item;
    end
  end

endmodule

// ===== rtl/lbre_div.sv =====
// Restoring divider, one quotient bit per cycle, variable step count.
`timescale 1ns / 1ps
module lbre_div (
  input  logic                clk,
  input  logic                rst,
  input  lbre_pkg::div_req_t  req,
  output lbre_pkg::div_rsp_t  rsp
);

  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [19:0] rem;
  logic [31:0] q;
  logic [19:0] dvs;
  logic [63:0] wide;
  logic [20:0] trial;
  logic        ge;

  // Caller guarantees dividend >> nsteps is below the divisor
  assign wide = {32'b0, req.dividend};
  assign trial = {rem, q[31]};
  assign ge = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= !req.start && busy && (cnt == 6'd1);
      if (req.start) begin
        busy <= 1'b1;
        cnt <= req.nsteps;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
    if (req.start) begin
      dvs <= req.divisor;
      rem <= 20'(wide >> req.nsteps);
      q <= 32'(wide << (6'd32 - req.nsteps));
    end else if (busy) begin
      rem <= ge ? 20'(trial - {1'b0, dvs}) : trial[19:0];
      q <= {q[30:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = q;
  assign rsp.rem = rem;

endmodule

// ===== rtl/lbre_back.sv =====
// Back end: walks the banks of one active item and emits a duty value per bank; a finished item gives one result.
`timescale 1ns / 1ps
module lbre_back (
  input  logic               clk,
  input  logic               rst,
  input  lbre_pkg::cfg_t     cfg,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  lbre_pkg::item_t    pop_item,
  output lbre_pkg::div_req_t div_req,
  input  lbre_pkg::div_rsp_t div_rsp,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         bank_index,
  output logic [7:0]         duty_level,
  output logic               last_bank,
  output logic               finished
);

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_MWAIT, S_BANK, S_CENT, S_CHK, S_CWAIT,
    S_TRI, S_DSTART, S_DWAIT, S_EMIT
  } state_t;

  state_t      st;
  logic [31:0] t_r;
  logic        fin_r;
  logic [19:0] tc;
  logic [lbre_pkg::BANK_W-1:0] bank;
  logic [3:0]  dlin;
  logic [7:0]  dsq;
  logic [23:0] xval;
  logic [23:0] centre;
  logic [23:0] num;
  logic [7:0]  duty;

  logic [3:0]  dlin_c;
  logic [3:0]  distb_c;
  logic [31:0] tref;
  logic [31:0] cen32;
  logic [31:0] dist_c;
  logic [7:0]  peak_c;
  logic        out_free;

  assign pop_ready = (st == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Per-bank distances
  assign dlin_c = (bank >= cfg.origin) ? bank - cfg.origin : cfg.origin - bank;
  assign distb_c = (bank >= cfg.anchor) ? 4'd0 : cfg.anchor - bank;

  // Triangle distance from the pulse centre
  assign tref = (cfg.mode == lbre_pkg::MODE_BLOW) ? t_r : {12'b0, tc};
  assign cen32 = {8'b0, centre};
  assign dist_c = (tref >= cen32) ? tref - cen32 : cen32 - tref;
  assign peak_c = (cfg.mode == lbre_pkg::MODE_BLOW) ? lbre_pkg::BLOW_PEAK : cfg.peak;

  // Divider requests
  always_comb begin
    div_req = '0;
    unique case (st)
      S_MOD: begin
        div_req.start = 1'b1;
        div_req.dividend = t_r;
        div_req.divisor = cfg.cycle;
        div_req.nsteps = 6'd32;
      end
      S_CHK: begin
        div_req.start = (cfg.anchor != 4'd0) && (xval != 24'd0);
        div_req.dividend = {8'b0, xval};
        div_req.divisor = {16'b0, cfg.anchor};
        div_req.nsteps = 6'd24;
      end
      S_DSTART: begin
        div_req.start = 1'b1;
        div_req.dividend = {8'b0, num};
        div_req.divisor = {4'b0, cfg.step};
        div_req.nsteps = 6'd8;
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_ready && st != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (pop_valid) begin
            t_r <= pop_item.t;
            fin_r <= pop_item.fin;
            bank <= '0;
            if (pop_item.fin) begin
              st <= S_EMIT;
            end else if (cfg.mode == lbre_pkg::MODE_BLOW) begin
              st <= S_BANK;
            end else begin
              st <= S_MOD;
            end
          end
        end
        S_MOD: begin
          st <= S_MWAIT;
        end
        S_MWAIT: begin
          if (div_rsp.done) begin
            tc <= div_rsp.rem;
            st <= S_BANK;
          end
        end
        S_BANK: begin
          dlin <= dlin_c;
          dsq <= 8'(distb_c) * 8'(distb_c);
          st <= S_CENT;
        end
        S_CENT: begin
          if (cfg.mode == lbre_pkg::MODE_BLOW) begin
            xval <= 24'(dsq) * 24'(cfg.step);
            st <= S_CHK;
          end else begin
            centre <= 24'(dlin) * 24'(cfg.step);
            st <= S_TRI;
          end
        end
        S_CHK: begin
          // centre = step * dist^2 / anchor; zero when nothing to divide
          if (cfg.anchor == 4'd0 || xval == 24'd0) begin
            centre <= '0;
            st <= S_TRI;
          end else begin
            st <= S_CWAIT;
          end
        end
        S_CWAIT: begin
          if (div_rsp.done) begin
            centre <= div_rsp.quot[23:0];
            st <= S_TRI;
          end
        end
        S_TRI: begin
          if (cfg.mode == lbre_pkg::MODE_OUTWARD && bank == cfg.origin) begin
            duty <= cfg.peak;
            st <= S_EMIT;
          end else if (dist_c >= {16'b0, cfg.step}) begin
            duty <= '0;
            st <= S_EMIT;
          end else begin
            num <= 24'(peak_c) * 24'(cfg.step - dist_c[15:0]);
            st <= S_DSTART;
          end
        end
        S_DSTART: begin
          st <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_rsp.done) begin
            duty <= div_rsp.quot[7:0];
            st <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (fin_r) begin
              bank_index <= '0;
              duty_level <= '0;
              last_bank <= 1'b1;
              finished <= 1'b1;
              st <= S_IDLE;
            end else begin
              bank_index <= bank;
              duty_level <= duty;
              last_bank <= (bank == lbre_pkg::LAST_BANK);
              finished <= 1'b0;
              if (bank == lbre_pkg::LAST_BANK) begin
                st <= S_IDLE;
              end else begin
                bank <= bank + 1'b1;
                st <= S_BANK;
              end
            end
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/led_bank_ripple_envelope.sv =====
// Top level of the LED bank ripple envelope: registers, front, queue, back.
//
//  channel | signals                                      | dir
//  --------+----------------------------------------------+-----
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data        | in
//  in      | in_valid in_ready elapsed_ms                 | in
//  out     | out_valid out_ready bank_index duty_level     | out
//          | last_bank finished                           |
//
// A finished item passes the back end without the divider; an outward item
// uses the serial divider (one quotient bit a cycle) once for its time modulo
// the cycle length and then per bank, where needed, for the duty, a blow item
// per bank for the pulse centre and for the duty. The front keeps taking items
// into a 4-entry queue while the back works. Reset is synchronous and loads the
// register defaults; no clearing pass. Either side may stall at any time.
`timescale 1ns / 1ps
module led_bank_ripple_envelope (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] elapsed_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  bank_index,
  output logic [7:0]  duty_level,
  output logic        last_bank,
  output logic        finished
);

  logic        mode;
  logic [3:0]  origin;
  logic [15:0] step;
  logic [7:0]  peak;
  logic [7:0]  passes;
  logic [3:0]  anchor;
  logic [3:0]  org_c;
  logic [3:0]  maxd_c;
  logic [19:0] cycle;
  logic [27:0] total;

  lbre_pkg::cfg_t     cfg;
  lbre_pkg::item_t    push_item;
  lbre_pkg::item_t    pop_item;
  lbre_pkg::div_req_t div_req;
  lbre_pkg::div_rsp_t div_rsp;
  logic push_valid;
  logic push_ready;
  logic pop_valid;
  logic pop_ready;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= lbre_pkg::MODE_OUTWARD;
      origin <= 4'd4;
      step <= 16'd80;
      peak <= 8'd100;
      passes <= 8'd1;
      anchor <= 4'd7;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lbre_pkg::REG_MODE:   mode <= cfg_data[0];
        lbre_pkg::REG_ORIGIN: origin <= cfg_data[3:0];
        lbre_pkg::REG_STEP:   step <= cfg_data;
        lbre_pkg::REG_PEAK:   peak <= cfg_data[7:0];
        lbre_pkg::REG_PASSES: passes <= cfg_data[7:0];
        lbre_pkg::REG_ANCHOR: anchor <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Derived cycle length and total duration
  assign org_c = (origin > lbre_pkg::LAST_BANK) ? lbre_pkg::LAST_BANK : origin;
  assign maxd_c = (org_c > lbre_pkg::LAST_BANK - org_c) ? org_c
                                                         : lbre_pkg::LAST_BANK - org_c;

  always_ff @(posedge clk) begin
    cycle <= 20'(step) * 20'({1'b0, maxd_c} + 5'd2);
    if (mode == lbre_pkg::MODE_BLOW) begin
      total <= 28'({1'b0, anchor} + 5'd1) * 28'(step);
    end else begin
      total <= 28'(cycle) * 28'(passes);
    end
  end

  assign cfg.mode = mode;
  assign cfg.origin = org_c;
  assign cfg.step = step;
  assign cfg.peak = peak;
  assign cfg.anchor = anchor;
  assign cfg.cycle = cycle;

  lbre_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .elapsed_ms (elapsed_ms),
    .total      (total),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  lbre_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_item  (push_item),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_item  (pop_item)
  );

  lbre_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  lbre_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .bank_index (bank_index),
    .duty_level (duty_level),
    .last_bank  (last_bank),
    .finished   (finished)
  );

  // A finished result is a single dark result at bank zero
  a_fin_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> last_bank && bank_index == '0 && duty_level == '0)
    else $error("finished result malformed");

  // Blow pulses never exceed their fixed peak
  a_blow_peak: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode == lbre_pkg::MODE_BLOW |-> duty_level <= lbre_pkg::BLOW_PEAK)
    else $error("blow duty above peak");

  // The last bank flag marks exactly the last bank of an active item
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && !finished |-> last_bank == (bank_index == lbre_pkg::LAST_BANK))
    else $error("last bank flag mismatch");

endmodule

// ===== tb/sv/led_bank_ripple_envelope_tb.sv =====
// Self-checking testbench of the LED bank ripple envelope.
`timescale 1ns / 1ps
module led_bank_ripple_envelope_tb;

  // Indexes past the register list; writes to them must change nothing
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] elapsed_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  bank_index;
  logic [7:0]  duty_level;
  logic        last_bank;
  logic        finished;

  typedef struct packed {
    logic [3:0] bank;
    logic [7:0] duty;
    logic       last;
    logic       fin;
  } duty_beat_t;

  duty_beat_t pending_duties[$];
  int         fail_count = 0;
  int         mismatch_count = 0;
  bit         quiet = 1'b0;
  int         out_stall = 0;

  // Shadow copy of the registers
  logic        sh_mode;
  logic [3:0]  sh_origin;
  logic [15:0] sh_step;
  logic [7:0]  sh_peak;
  logic [7:0]  sh_passes;
  logic [3:0]  sh_anchor;

  led_bank_ripple_envelope dut (.*);

  always #6 clk = ~clk;

  // Gap length: mostly short, now and then long
  function automatic int pick_gap();
    if (quiet) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic longint unsigned triangle(longint unsigned t, longint unsigned ctr,
                                               longint unsigned hw, longint unsigned pk);
    longint unsigned offset;
    offset = (t >= ctr) ? t - ctr : ctr - t;
    if (hw == 0 || offset >= hw) return 0;
    return (pk * (hw - offset)) / hw;
  endfunction

  // Total ripple length under the current registers
  function automatic longint unsigned ripple_total();
    longint unsigned org, maxd;
    if (sh_mode == lbre_pkg::MODE_BLOW) return longint'(sh_anchor) * sh_step + sh_step;
    org = (sh_origin > lbre_pkg::BANK_COUNT - 1) ? lbre_pkg::BANK_COUNT - 1 : sh_origin;
    maxd = (org > lbre_pkg::BANK_COUNT - 1 - org) ? org : lbre_pkg::BANK_COUNT - 1 - org;
    return longint'(sh_step) * (maxd + 2) * sh_passes;
  endfunction

  // Expected duties of one time item
  function automatic void predict_duties(logic [31:0] t_in);
    longint unsigned t, org, maxd, cyc, tc, d, ctr, anc, duty;
    duty_beat_t beat;
    t = t_in;
    if (sh_mode == lbre_pkg::MODE_OUTWARD) begin
      org = (sh_origin > lbre_pkg::BANK_COUNT - 1) ? lbre_pkg::BANK_COUNT - 1 : sh_origin;
      maxd = (org > lbre_pkg::BANK_COUNT - 1 - org) ? org : lbre_pkg::BANK_COUNT - 1 - org;
      cyc = longint'(sh_step) * (maxd + 2);
    end
    if (t >= ripple_total() || (sh_mode == lbre_pkg::MODE_OUTWARD && cyc == 0)) begin
      beat = '{bank: 4'd0, duty: 8'd0, last: 1'b1, fin: 1'b1};
      pending_duties.push_back(beat);
      return;
    end
    anc = sh_anchor;
    for (int b = 0; b < lbre_pkg::BANK_COUNT; b++) begin
      if (sh_mode == lbre_pkg::MODE_OUTWARD) begin
        tc = t % cyc;
        if (b == org) duty = sh_peak;
        else begin
          d = (b > org) ? b - org : org - b;
          duty = triangle(tc, d * sh_step, sh_step, sh_peak);
        end
      end else begin
        d = (b >= anc) ? 0 : anc - b;
        ctr = (anc != 0) ? (anc * sh_step * d * d) / (anc * anc) : 0;
        duty = triangle(t, ctr, sh_step, lbre_pkg::BLOW_PEAK);
      end
      beat = '{bank: 4'(b), duty: 8'(duty), last: (b == lbre_pkg::BANK_COUNT - 1),
               fin: 1'b0};
      pending_duties.push_back(beat);
    end
  endfunction

  // Register write; only called with nothing in flight
  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      lbre_pkg::REG_MODE:   sh_mode   = data[0];
      lbre_pkg::REG_ORIGIN: sh_origin = data[3:0];
      lbre_pkg::REG_STEP:   sh_step   = data;
      lbre_pkg::REG_PEAK:   sh_peak   = data[7:0];
      lbre_pkg::REG_PASSES: sh_passes = data[7:0];
      lbre_pkg::REG_ANCHOR: sh_anchor = data[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_ripple(logic m, logic [3:0] org, logic [15:0] st, logic [7:0] pk,
                            logic [7:0] ps, logic [3:0] anc);
    write_reg(lbre_pkg::REG_MODE, 16'(m));
    write_reg(lbre_pkg::REG_ORIGIN, 16'(org));
    write_reg(lbre_pkg::REG_STEP, st);
    write_reg(lbre_pkg::REG_PEAK, 16'(pk));
    write_reg(lbre_pkg::REG_PASSES, 16'(ps));
    write_reg(lbre_pkg::REG_ANCHOR, 16'(anc));
  endtask

  // One time item transfer; valid stays high if no gap follows
  task automatic send_time(logic [31:0] t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    elapsed_ms <= t;
    predict_duties(t);
    do @(posedge clk); while (!in_ready);
  endtask

  // Wait until every expected duty has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_duties.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Times around the ripple edges plus a random one
  function automatic logic [31:0] pick_time();
    longint unsigned tot;
    int r;
    tot = ripple_total();
    r = $urandom_range(0, 9);
    if (tot != 0 && r < 7) return 32'($urandom_range(0, 32'(tot - 1)));
    if (r == 7) return 32'(tot);
    if (r == 8 && tot != 0) return 32'(tot - 1);
    return $urandom();
  endfunction

  task automatic test_defaults();
    sh_mode = lbre_pkg::MODE_OUTWARD; sh_origin = 4'd4; sh_step = 16'd80;
    sh_peak = 8'd100; sh_passes = 8'd1; sh_anchor = 4'd7;
    send_time(32'd0);
    send_time(32'd79);
    send_time(32'd80);
    send_time(32'd479);
    send_time(32'd480);
    send_time(32'hFFFF_FFFF);
    drain();
  endtask

  task automatic test_outward_extremes();
    set_ripple(lbre_pkg::MODE_OUTWARD, 4'd0, 16'd1, 8'd255, 8'd255, 4'd1);
    send_time(32'd0);
    send_time(32'd10);
    send_time(32'd2549);
    drain();
    set_ripple(lbre_pkg::MODE_OUTWARD, 4'd15, 16'd65535, 8'd0, 8'd3, 4'd8);
    send_time(32'd70000);
    send_time(32'd1966049);
    drain();
    set_ripple(lbre_pkg::MODE_OUTWARD, 4'd8, 16'd65535, 8'd255, 8'd255, 4'd8);
    send_time(32'hA000_0000);
    send_time(32'd100000);
    drain();
    // zero step and zero passes finish every item
    write_reg(lbre_pkg::REG_STEP, 16'd0);
    send_time(32'd0);
    drain();
    write_reg(lbre_pkg::REG_STEP, 16'd5);
    write_reg(lbre_pkg::REG_PASSES, 16'd0);
    send_time(32'd0);
    drain();
  endtask

  task automatic test_blow();
    set_ripple(lbre_pkg::MODE_BLOW, 4'd4, 16'd100, 8'd7, 8'd1, 4'd0);
    send_time(32'd0);
    send_time(32'd50);
    drain();
    write_reg(lbre_pkg::REG_ANCHOR, 16'd1);
    send_time(32'd30);
    drain();
    write_reg(lbre_pkg::REG_ANCHOR, 16'd8);
    send_time(32'd250);
    send_time(32'd899);
    drain();
    // anchor past the banks keeps every distance nonzero
    write_reg(lbre_pkg::REG_ANCHOR, 16'd15);
    write_reg(lbre_pkg::REG_STEP, 16'd65535);
    send_time(32'd500000);
    send_time(32'd1048559);
    drain();
  endtask

  task automatic test_wide_values();
    quiet = 1'b1;
    write_reg(lbre_pkg::REG_MODE, 16'hFFFE);
    write_reg(lbre_pkg::REG_ORIGIN, 16'hFFF3);
    write_reg(lbre_pkg::REG_PEAK, 16'hAB80);
    write_reg(lbre_pkg::REG_PASSES, 16'h5502);
    write_reg(lbre_pkg::REG_STEP, 16'd40);
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h0001);
    send_time(32'd55);
    send_time(32'd300);
    drain();
    write_reg(lbre_pkg::REG_MODE, 16'hFFFF);
    write_reg(lbre_pkg::REG_ANCHOR, 16'hF0F6);
    send_time(32'd120);
    drain();
    quiet = 1'b0;
  endtask

  task automatic test_random();
    int sent;
    logic [15:0] st;
    sent = 0;
    while (sent < 80) begin
      st = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 300));
      set_ripple(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), st, 8'($urandom()),
                 8'(($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(1, 4)),
                 4'($urandom_range(0, 15)));
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(4, 14)) begin
        send_time(pick_time());
        sent++;
      end
      drain();
    end
    quiet = 1'b0;
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) out_stall <= pick_gap() + 1;
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    duty_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_duties.size() == 0) begin
        fail_count++;
        if (mismatch_count < 10)
          $display("unexpected result bank=%0d duty=%0d last=%0b fin=%0b",
                   bank_index, duty_level, last_bank, finished);
        mismatch_count++;
      end else begin
        want = pending_duties.pop_front();
        if (want.bank !== bank_index || want.duty !== duty_level ||
            want.last !== last_bank || want.fin !== finished) begin
          fail_count++;
          if (mismatch_count < 10)
            $display("mismatch exp bank=%0d duty=%0d last=%0b fin=%0b, got %0d %0d %0b %0b",
                     want.bank, want.duty, want.last, want.fin,
                     bank_index, duty_level, last_bank, finished);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #30_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_outward_extremes();
    test_blow();
    test_wide_values();
    test_random();
    drain();
    repeat (500) @(posedge clk);
    if (fail_count == 0 && pending_duties.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
